// ===== sv/olte_pkg.sv =====
package olte_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 64;
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int OUT_IDX_W = 4;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             write_new;   // store new entry at target
        logic             shift_up;    // entries above target take lower neighbor
        logic             shift_down;  // entries from target take upper neighbor
        logic [CNT_W-1:0] target;
        logic [CNT_W-1:0] count;       // count before the operation
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } cell_ctrl_t;

endpackage

// ===== sv/olte_cell.sv =====
module olte_cell (
    input  logic                     clk,
    input  logic [olte_pkg::IDX_W-1:0] cell_idx,
    input  olte_pkg::cell_ctrl_t     ctrl,
    input  logic [olte_pkg::KEY_W-1:0] lower_key,
    input  logic [olte_pkg::PAY_W-1:0] lower_payload,
    input  logic [olte_pkg::KEY_W-1:0] upper_key,
    input  logic [olte_pkg::PAY_W-1:0] upper_payload,
    output logic [olte_pkg::KEY_W-1:0] cell_key,
    output logic [olte_pkg::PAY_W-1:0] cell_payload,
    output logic                     match
);
    import olte_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [PAY_W-1:0] payload_reg;
    logic [PAY_W-1:0] payload_next;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] slot_plus;

    assign slot      = CNT_W'(cell_idx);
    assign slot_plus = slot + CNT_W'(1);

    // only live entries can match
    assign match = (key_reg == ctrl.key) && (slot < ctrl.count);

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        priority if (ctrl.write_new && (slot == ctrl.target))
        begin
            key_next     = ctrl.key;
            payload_next = ctrl.payload;
        end
        else if (ctrl.shift_up && (slot > ctrl.target) && (slot <= ctrl.count))
        begin
            key_next     = lower_key;
            payload_next = lower_payload;
        end
        else if (ctrl.shift_down && (slot >= ctrl.target) && (slot_plus < ctrl.count))
        begin
            key_next     = upper_key;
            payload_next = upper_payload;
        end
        else
        begin
            // untouched cells keep their entry
            key_next     = key_reg;
            payload_next = payload_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign cell_key     = key_reg;
    assign cell_payload = payload_reg;

endmodule

// ===== sv/ordered_list_table_engine_unit.sv =====
// channel  | handshake            | fields
// ---------+----------------------+------------------------------------
// input    | in_valid / in_stall  | operation, key, payload, position
// output   | out_valid / out_stall| status, index, count
//
// one item per cycle while in_stall is low; its result appears in the output register on the next cycle
// the chain of cells compares every live key at once, a priority pick selects the
// first hit, and the cells that move all shift with their neighbor in the same edge
// in_stall rises only while a result sits in the output register and out_stall is high
// reset clears the entry count and the output valid; stored entries are undefined
// until written and are never read beyond the count
module ordered_list_table_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [olte_pkg::OP_W-1:0]     operation,
    input  logic signed [olte_pkg::KEY_W-1:0] key,
    input  logic [olte_pkg::PAY_W-1:0]    payload,
    input  logic [olte_pkg::POS_W-1:0]    position,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [olte_pkg::OUT_IDX_W-1:0] index,
    output logic [olte_pkg::OUT_CNT_W-1:0] count
);
    import olte_pkg::*;

    // list state
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    // output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [OUT_IDX_W-1:0] index_reg;
    logic [OUT_IDX_W-1:0] index_next;

    logic                 accept;
    cell_ctrl_t           ctrl;

    logic [KEY_W-1:0]     cell_key     [CAPACITY];
    logic [PAY_W-1:0]     cell_payload [CAPACITY];
    logic [CAPACITY-1:0]  match_vec;

    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic                 is_full;
    logic [CNT_W-1:0]     pos_ext;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign pos_ext  = CNT_W'(position);

    // first live entry whose key matches
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // decode the item into the cell broadcast and the result
    always_comb
    begin
        ctrl            = '0;
        ctrl.count      = count_reg;
        ctrl.key        = key;
        ctrl.payload    = payload;
        count_next      = count_reg;
        status_next     = status_reg;
        index_next      = index_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            index_next     = '0;
            unique case (operation)
                OP_APPEND:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.write_new = 1'b1;
                        ctrl.target    = count_reg;
                        index_next     = OUT_IDX_W'(count_reg);
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                OP_INSERT:
                begin
                    priority if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (pos_ext > count_reg)
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        ctrl.write_new = 1'b1;
                        ctrl.shift_up  = 1'b1;
                        ctrl.target    = pos_ext;
                        index_next     = OUT_IDX_W'(pos_ext);
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (!hit)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        ctrl.shift_down = 1'b1;
                        ctrl.target     = CNT_W'(hit_idx);
                        index_next      = OUT_IDX_W'(hit_idx);
                        count_next      = count_reg - CNT_W'(1);
                    end
                end
                OP_SEARCH:
                begin
                    if (!hit)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        index_next = OUT_IDX_W'(hit_idx);
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    // unused codes leave the list untouched
                end
            endcase
        end
    end

    // the chain: each cell sees its lower and upper neighbor
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [KEY_W-1:0] lo_key;
        logic [PAY_W-1:0] lo_payload;
        logic [KEY_W-1:0] hi_key;
        logic [PAY_W-1:0] hi_payload;

        if (g == 0)
        begin : g_bottom
            assign lo_key     = '0;
            assign lo_payload = '0;
        end
        else
        begin : g_lower
            assign lo_key     = cell_key[g-1];
            assign lo_payload = cell_payload[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_top
            assign hi_key     = '0;
            assign hi_payload = '0;
        end
        else
        begin : g_upper
            assign hi_key     = cell_key[g+1];
            assign hi_payload = cell_payload[g+1];
        end

        olte_cell u_cell (
            .clk           (clk),
            .cell_idx      (IDX_W'(g)),
            .ctrl          (ctrl),
            .lower_key     (lo_key),
            .lower_payload (lo_payload),
            .upper_key     (hi_key),
            .upper_payload (hi_payload),
            .cell_key      (cell_key[g]),
            .cell_payload  (cell_payload[g]),
            .match         (match_vec[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        index_reg  <= index_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign index     = index_reg;
    assign count     = OUT_CNT_W'(count_reg);

    // the list never grows past its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // clear empties the list
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries");

    // a successful append grows the list by one
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == OP_APPEND) && !is_full
        |=> (count_reg == $past(count_reg) + CNT_W'(1)) && (status_reg == ST_OK))
        else $error("append did not grow the list");

    // a failed lookup reports index zero and keeps the count
    a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((operation == OP_DELETE) || (operation == OP_SEARCH)) && !hit
        |=> (index_reg == '0) && (status_reg == ST_NOTFOUND)
            && (count_reg == $past(count_reg)))
        else $error("miss changed the list or reported an index");

endmodule

// ===== sim/tb.sv =====
// self-checking bench for the ordered list table engine
// a scoreboard copy of the list predicts status, index and count for every item
// both channels idle and stall at random, with calm stretches and full drains

module tb;
    import olte_pkg::*;

    // operation codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int DIR_ROWS   = 21;
    localparam int RAND_ITEMS = 1920;
    localparam int PHASE_LEN  = 160;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [1:0]           st;
        logic [OUT_IDX_W-1:0] idx;
        logic [OUT_CNT_W-1:0] cnt;
    } list_result_t;

    // one row of the directed table; known rows carry a hand-written result
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] k;
        logic [PAY_W-1:0] d;
        logic [POS_W-1:0] p;
        logic [4:0]       reps;
        logic             known;
        list_result_t     res;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      operation = '0;
    logic [KEY_W-1:0]     key       = '0;
    logic [PAY_W-1:0]     payload   = '0;
    logic [POS_W-1:0]     position  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [OUT_IDX_W-1:0] index;
    logic [OUT_CNT_W-1:0] count;

    // scoreboard copy of the list
    logic [KEY_W-1:0] list_keys [CAPACITY];
    logic [PAY_W-1:0] list_data [CAPACITY];
    int               list_len = 0;

    list_result_t pending_results [$];
    list_result_t seen_result;
    list_result_t due_result;

    int  fault_count   = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  stall_left    = 0;
    bit  calm          = 1'b0;
    int  op_seen [8]   = '{default: 0};
    int  status_seen [4] = '{default: 0};

    // walk through the empty, full and cleared corners by hand
    dir_row_t dir_table [DIR_ROWS] = '{
        // empty list: nothing matches, any nonzero position is out of range
        '{OP_SEARCH, 32'h0000_0000, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_NOTFOUND, 4'd0, 5'd0}},
        '{OP_DELETE, 32'hFFFF_FFFF, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_NOTFOUND, 4'd0, 5'd0}},
        '{OP_INSERT, 32'h0000_0001, 64'h0, 5'd1, 5'd1, 1'b1, '{ST_BADPOS, 4'd0, 5'd0}},
        // key and payload extremes
        '{OP_APPEND, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 5'd1, 1'b1,
          '{ST_OK, 4'd0, 5'd1}},
        '{OP_APPEND, 32'h8000_0000, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_OK, 4'd1, 5'd2}},
        // insert at the head and at the tail
        '{OP_INSERT, 32'hFFFF_FFFF, 64'hA5A5_A5A5_A5A5_A5A5, 5'd0, 5'd1, 1'b1,
          '{ST_OK, 4'd0, 5'd3}},
        '{OP_INSERT, 32'h0000_0000, 64'h5A5A_5A5A_5A5A_5A5A, 5'd3, 5'd1, 1'b1,
          '{ST_OK, 4'd3, 5'd4}},
        '{OP_INSERT, 32'h0000_0002, 64'h0, 5'd31, 5'd1, 1'b1, '{ST_BADPOS, 4'd0, 5'd4}},
        '{OP_SEARCH, 32'h8000_0000, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_OK, 4'd2, 5'd4}},
        '{OP_DELETE, 32'h7FFF_FFFF, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_OK, 4'd1, 5'd3}},
        // fill to capacity with duplicate keys
        '{OP_APPEND, 32'h0000_0005, 64'h1234_5678_9ABC_DEF0, 5'd0, 5'd13, 1'b0,
          '{ST_OK, 4'd0, 5'd0}},
        // full wins over a bad position
        '{OP_APPEND, 32'h0000_0006, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_FULL, 4'd0, 5'd16}},
        '{OP_INSERT, 32'h0000_0006, 64'h0, 5'd31, 5'd1, 1'b1, '{ST_FULL, 4'd0, 5'd16}},
        // first of the duplicates goes, then the last slot is used and freed
        '{OP_DELETE, 32'h0000_0005, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_OK, 4'd3, 5'd15}},
        '{OP_INSERT, 32'h0000_0009, 64'h0, 5'd15, 5'd1, 1'b1, '{ST_OK, 4'd15, 5'd16}},
        '{OP_DELETE, 32'h0000_0009, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_OK, 4'd15, 5'd15}},
        // unused codes leave everything alone
        '{OP_SPARE5, 32'h0000_0005, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_OK, 4'd0, 5'd15}},
        '{OP_SPARE7, 32'hFFFF_FFFF, 64'h0, 5'd31, 5'd1, 1'b1, '{ST_OK, 4'd0, 5'd15}},
        // stale entries after a clear must not match
        '{OP_CLEAR, 32'h0000_0000, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_OK, 4'd0, 5'd0}},
        '{OP_SEARCH, 32'hFFFF_FFFF, 64'h0, 5'd0, 5'd1, 1'b1, '{ST_NOTFOUND, 4'd0, 5'd0}},
        '{OP_INSERT, 32'h0000_1234, 64'hDEAD_BEEF_0000_0001, 5'd0, 5'd1, 1'b0,
          '{ST_OK, 4'd0, 5'd0}}
    };

    ordered_list_table_engine_unit u_top (.*);

    always #5 clk = ~clk;

    // apply one operation to the scoreboard list and return what the block should report
    function automatic void list_apply(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                                       input logic [PAY_W-1:0] d, input logic [POS_W-1:0] p,
                                       output list_result_t r);
        int i;
        int hit;
        r   = '{ST_OK, '0, '0};
        hit = -1;
        for (i = 0; i < list_len; i++)
        begin
            if (hit < 0 && list_keys[i] == k)
                hit = i;
        end
        case (op)
            OP_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    list_keys[list_len] = k;
                    list_data[list_len] = d;
                    r.idx = OUT_IDX_W'(list_len);
                    list_len++;
                end
            end
            OP_INSERT:
            begin
                // fullness is judged before the position
                if (list_len >= CAPACITY)
                    r.st = ST_FULL;
                else if (int'(p) > list_len)
                    r.st = ST_BADPOS;
                else
                begin
                    for (i = list_len; i > int'(p); i--)
                    begin
                        list_keys[i] = list_keys[i-1];
                        list_data[i] = list_data[i-1];
                    end
                    list_keys[p] = k;
                    list_data[p] = d;
                    r.idx = OUT_IDX_W'(p);
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                if (hit < 0)
                    r.st = ST_NOTFOUND;
                else
                begin
                    r.idx = OUT_IDX_W'(hit);
                    for (i = hit; i + 1 < list_len; i++)
                    begin
                        list_keys[i] = list_keys[i+1];
                        list_data[i] = list_data[i+1];
                    end
                    list_len--;
                end
            end
            OP_SEARCH:
            begin
                if (hit < 0)
                    r.st = ST_NOTFOUND;
                else
                    r.idx = OUT_IDX_W'(hit);
            end
            OP_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        r.cnt = OUT_CNT_W'(list_len);
    endfunction

    // mostly a live key, often a small shared one, sometimes anything
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (list_len > 0 && roll < 55)
            return list_keys[$urandom_range(0, list_len - 1)];
        else if (roll < 85)
            return KEY_W'($urandom_range(0, 7)) - KEY_W'(4);
        else
            return KEY_W'($urandom);
    endfunction

    // present one item after a random gap, hold it until taken, then predict its result
    task automatic push_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [PAY_W-1:0] d, input logic [POS_W-1:0] p,
                             input logic known, input list_result_t typed);
        int gap;
        list_result_t res;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        payload   <= d;
        position  <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        list_apply(op, k, d, p, res);
        // typed-in rows still advance the scoreboard list
        pending_results.push_back(known ? typed : res);
        op_seen[op]++;
        items_sent++;
    endtask

    // hold the sender off until every outstanding result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result side: check each taken item, then draw the stall before the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen_result = '{status, index, count};
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORT)
                        $display("unexpected result: status %0d index %0d count %0d",
                                 status, index, count);
                end
                else
                begin
                    due_result = pending_results.pop_front();
                    status_seen[seen_result.st]++;
                    if (seen_result !== due_result)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_REPORT)
                            $display("mismatch on result %0d: want status %0d index %0d count %0d, got status %0d index %0d count %0d",
                                     results_seen, due_result.st, due_result.idx, due_result.cnt,
                                     seen_result.st, seen_result.idx, seen_result.cnt);
                    end
                end
                stall_left = calm ? 0 : $urandom_range(0, 3);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // main sequence
    initial
    begin
        int n;
        int rep;
        int roll;
        int grow;
        int guard;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] k;
        logic [POS_W-1:0] p;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        foreach (dir_table[r])
        begin
            for (rep = 0; rep < dir_table[r].reps; rep++)
                push_item(dir_table[r].op, dir_table[r].k, dir_table[r].d, dir_table[r].p,
                          dir_table[r].known, dir_table[r].res);
        end
        drain_results();

        // random traffic in phases that alternately grow and shrink the list
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n != 0 && n % PHASE_LEN == 0)
                drain_results();
            calm = ((n / PHASE_LEN) % 4 == 3);
            grow = ((n / PHASE_LEN) % 2 == 0) ? 50 : 28;
            roll = $urandom_range(0, 99);
            k    = pick_key();
            p    = '0;
            if (roll < grow)
            begin
                if ($urandom_range(0, 1) == 0)
                    op = OP_APPEND;
                else
                begin
                    op = OP_INSERT;
                    p  = POS_W'($urandom_range(0, list_len));
                end
            end
            else if (roll < 73)
                op = OP_DELETE;
            else if (roll < 91)
                op = OP_SEARCH;
            else if (roll < 93)
                op = OP_CLEAR;
            else if (roll < 96)
                op = OP_W'($urandom_range(OP_SPARE5, OP_SPARE7));
            else
            begin
                // insert with any position, mostly out of range
                op = OP_INSERT;
                p  = POS_W'($urandom_range(0, 31));
            end
            push_item(op, k, {$urandom, $urandom}, p, 1'b0, '{ST_OK, '0, '0});
        end

        // let the last results come back, then watch a few more cycles for strays
        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            fault_count += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end

        $display("%0d items: append %0d, insert %0d, delete %0d, search %0d, clear %0d, no-op %0d",
                 items_sent, op_seen[OP_APPEND], op_seen[OP_INSERT], op_seen[OP_DELETE],
                 op_seen[OP_SEARCH], op_seen[OP_CLEAR],
                 op_seen[OP_SPARE5] + op_seen[OP_SPARE6] + op_seen[OP_SPARE7]);
        $display("statuses: ok %0d, full %0d, bad position %0d, not found %0d; %0d faults",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
                 status_seen[ST_NOTFOUND], fault_count);
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
